>>> sv/lcer_pkg.sv
package lcer_pkg;

    localparam int TAPS_MAX   = 13;
    localparam int LINE_MAX   = 4096;
    localparam int HALF_LIMIT = ((TAPS_MAX - 1) / 2 < 6) ? (TAPS_MAX - 1) / 2 : 6;
    localparam int COUNT_CAP  = (LINE_MAX > TAPS_MAX) ? LINE_MAX : TAPS_MAX;
    localparam int CNT_W      = $clog2(COUNT_CAP + 1);
    localparam int AGE_W      = $clog2(TAPS_MAX);
    localparam int NUM_REGS   = 8;

    // Sum of up to 13 products of 17 x 8 bits and the weight scale.
    localparam int SUM_W   = 29;
    localparam int SCALE_W = 21;
    localparam int QUO_W   = 9;

    localparam logic [2:0] REG_KERNEL_HALF   = 3'd0;
    localparam logic [2:0] REG_WEIGHT_CENTER = 3'd1;

    typedef struct packed {
        logic [7:0] in_pixel;
        logic       in_line_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       out_line_end;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic             shift_in;
        logic             row_start;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] newest;
        logic             row_last;
        logic             out_take;
    } lcer_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic busy;
        logic out_full;
    } lcer_sts_t;

endpackage

>>> sv/lcer_ctrl.sv
module lcer_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lcer_pkg::in_item_t      in_data,
    input  logic [2:0]              half_eff,
    input  lcer_pkg::lcer_sts_t     sts,
    output lcer_pkg::lcer_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROWS  = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [lcer_pkg::CNT_W-1:0]  seen_reg, seen_next;
    logic [lcer_pkg::CNT_W-1:0]  row_reg, row_next;
    logic [lcer_pkg::CNT_W-1:0]  newest_reg, newest_next;
    logic                        flush_reg, flush_next;
    logic                        accept;
    logic [lcer_pkg::CNT_W-1:0]  h_ext;

    assign h_ext  = lcer_pkg::CNT_W'(half_eff);
    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        seen_next   = seen_reg;
        row_next    = row_reg;
        newest_next = newest_reg;
        flush_next  = flush_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.shift_in = 1'b1;
                    newest_next  = seen_reg;
                    flush_next   = in_data.in_line_end;
                    row_next     = (seen_reg >= h_ext) ? seen_reg - h_ext : '0;
                    if (in_data.in_line_end)
                    begin
                        seen_next  = '0;
                        state_next = ST_ROWS;
                    end
                    else
                    begin
                        if (seen_reg < lcer_pkg::CNT_W'(lcer_pkg::COUNT_CAP))
                            seen_next = seen_reg + 1'b1;
                        if (seen_reg >= h_ext)
                            state_next = ST_ROWS;
                    end
                end
            end
            ST_ROWS:
            begin
                // One row goes to the datapath when it is idle and the output slot is free.
                if (!sts.busy && !sts.out_full)
                begin
                    cmd.row_start = 1'b1;
                    cmd.row       = row_reg;
                    cmd.newest    = newest_reg;
                    cmd.row_last  = flush_reg && (row_reg == newest_reg);
                    if (!flush_reg || row_reg == newest_reg)
                        state_next = ST_WAIT;
                    else
                        row_next = row_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                // The output register holds the finished row, so the next
                // pixel can be taken while it waits.
                if (!sts.busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seen_reg   <= '0;
            row_reg    <= '0;
            newest_reg <= '0;
            flush_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seen_reg   <= seen_next;
            row_reg    <= row_next;
            newest_reg <= newest_next;
            flush_reg  <= flush_next;
        end
    end

endmodule

>>> sv/lcer_datapath.sv
module lcer_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lcer_pkg::in_item_t         in_data,
    input  logic [2:0]                 half_eff,
    input  logic [16:0]                weight_center,
    input  logic [6*16-1:0]            weight_off,
    input  lcer_pkg::lcer_cmd_t        cmd,
    output lcer_pkg::lcer_sts_t        sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lcer_pkg::out_item_t        out_data
);

    localparam int NT = 2 * lcer_pkg::HALF_LIMIT + 1;
    localparam int TW = $clog2(NT + 1);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MAC  = 3'd1;
    localparam logic [2:0] P_DIV  = 3'd2;
    localparam logic [2:0] P_DONE = 3'd3;

    logic [7:0] win_reg [lcer_pkg::TAPS_MAX];

    logic [2:0]                      ph_reg;
    logic [TW-1:0]                   tap_reg;
    logic signed [lcer_pkg::CNT_W+1:0] row_reg, newest_reg;
    logic                            last_reg;
    logic                            full_reg;
    logic [lcer_pkg::SUM_W-1:0]      sum_reg;
    logic [lcer_pkg::SCALE_W-1:0]    scale_reg;
    logic [24:0]                     prod_reg;
    logic                            prod_ok_reg;
    logic [16:0]                     wprod_reg;
    logic [lcer_pkg::SUM_W:0]        rem_reg;
    logic [lcer_pkg::QUO_W-1:0]      quo_reg;
    logic [3:0]                      dbit_reg;
    logic [7:0]                      res_reg;
    logic                            out_valid_reg;
    lcer_pkg::out_item_t             out_reg;

    // Tap address for the current step.
    logic signed [lcer_pkg::CNT_W+1:0] d_s, pos, age;
    logic [2:0]                      tap_dist;
    logic [16:0]                     w;
    logic                            tap_in_line;
    logic [lcer_pkg::SUM_W:0]        den2, num_try;
    logic [lcer_pkg::SUM_W+1:0]      rnd;

    assign d_s  = $signed({{(lcer_pkg::CNT_W-TW+2){1'b0}}, tap_reg})
                - $signed({{(lcer_pkg::CNT_W-1){1'b0}}, half_eff});
    assign pos  = row_reg + d_s;
    assign age  = newest_reg - pos;
    assign tap_dist = d_s[lcer_pkg::CNT_W+1] ? 3'(-d_s) : 3'(d_s);
    assign tap_in_line = !pos[lcer_pkg::CNT_W+1] && !age[lcer_pkg::CNT_W+1]
                       && (age < lcer_pkg::TAPS_MAX);

    always_comb
    begin
        if (tap_dist == 3'd0)
            w = weight_center;
        else
            w = {1'b0, weight_off[(tap_dist-3'd1)*16 +: 16]};
    end

    assign den2    = {scale_reg, 1'b0};
    assign num_try = rem_reg;
    assign rnd     = {2'b00, sum_reg} + (lcer_pkg::SUM_W+2)'(32768);

    assign sts.busy     = (ph_reg != P_IDLE);
    assign sts.out_full = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_in)
        begin
            for (int i = lcer_pkg::TAPS_MAX - 1; i > 0; i--)
                win_reg[i] <= win_reg[i-1];
            win_reg[0] <= in_data.in_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= P_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (ph_reg)
                P_IDLE:
                begin
                    if (cmd.row_start)
                    begin
                        ph_reg <= P_MAC;
                    end
                end
                P_MAC:
                begin
                    // One tap per cycle; the product is registered in prod_reg before it is summed.
                    if (tap_reg == TW'(2 * half_eff + 1))
                        ph_reg <= P_DIV;
                end
                P_DIV:
                begin
                    if (full_reg || scale_reg == '0 || dbit_reg == 4'd0)
                        ph_reg <= P_DONE;
                end
                P_DONE:
                begin
                    ph_reg        <= P_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    ph_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ph_reg)
            P_IDLE:
            begin
                if (cmd.row_start)
                begin
                    row_reg     <= $signed({2'b00, cmd.row});
                    newest_reg  <= $signed({2'b00, cmd.newest});
                    last_reg    <= cmd.row_last;
                    tap_reg     <= '0;
                    full_reg    <= 1'b1;
                    sum_reg     <= '0;
                    scale_reg   <= '0;
                    prod_ok_reg <= 1'b0;
                end
            end
            P_MAC:
            begin
                if (prod_ok_reg)
                begin
                    sum_reg   <= sum_reg + lcer_pkg::SUM_W'(prod_reg);
                    scale_reg <= scale_reg + lcer_pkg::SCALE_W'(wprod_reg);
                end
                if (tap_reg <= TW'(2 * half_eff))
                begin
                    prod_ok_reg <= tap_in_line;
                    if (tap_in_line)
                    begin
                        prod_reg  <= w * win_reg[age[lcer_pkg::AGE_W-1:0]];
                        wprod_reg <= w;
                    end
                    else
                        full_reg <= 1'b0;
                end
                else
                    prod_ok_reg <= 1'b0;
                tap_reg <= tap_reg + 1'b1;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dbit_reg <= 4'(lcer_pkg::QUO_W);
            end
            P_DIV:
            begin
                if (full_reg)
                    res_reg <= (rnd[lcer_pkg::SUM_W+1:16] > 255) ? 8'd255
                             : rnd[23:16];
                else if (scale_reg == '0)
                    res_reg <= 8'd0;
                else if (dbit_reg == 4'd0)
                    res_reg <= (quo_reg > 9'd255) ? 8'd255 : quo_reg[7:0];
                else if (dbit_reg == 4'(lcer_pkg::QUO_W))
                begin
                    // Restoring division of 2*sum+scale by 2*scale. A weighted
                    // mean of pixels stays below 256, so eight quotient bits do.
                    rem_reg  <= {sum_reg, 1'b0} + (lcer_pkg::SUM_W+1)'(scale_reg);
                    dbit_reg <= 4'(lcer_pkg::QUO_W - 1);
                end
                else
                begin
                    if (num_try >= (den2 << (dbit_reg - 4'd1)))
                    begin
                        rem_reg <= num_try - (den2 << (dbit_reg - 4'd1));
                        quo_reg[dbit_reg-4'd1] <= 1'b1;
                    end
                    dbit_reg <= dbit_reg - 4'd1;
                end
            end
            P_DONE:
            begin
                out_reg.out_pixel    <= res_reg;
                out_reg.out_line_end <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> sv/line_convolution_edge_renorm.sv
// Symmetric blur of one pixel line with up to 13 taps and edge renormalization.
// Pixels enter on in_valid/in_ready, one beat each; in_line_end marks the last
// pixel, which flushes up to kernel_half+1 blurred pixels. Each result holds the
// shared multiply-accumulate unit, and after it the serial divider when that
// renormalizes a row near either end of the line. The next pixel is accepted
// only after the datapath has finished the results of the one before, and no
// row is issued while the output is stalled; the first kernel_half pixels of a
// line yield no result and are not held up. Weights must be written over the
// APB port only while the block is idle; the block itself does not enforce it.
module line_convolution_edge_renorm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lcer_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lcer_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [2:0]          kernel_half_reg;
    logic [16:0]         weight_center_reg;
    logic [6*16-1:0]     weight_off_reg;
    logic [2:0]          half_eff;
    logic [2:0]          ridx;
    lcer_pkg::lcer_cmd_t cmd;
    lcer_pkg::lcer_sts_t sts;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign half_eff = (kernel_half_reg > 3'(lcer_pkg::HALF_LIMIT))
                    ? 3'(lcer_pkg::HALF_LIMIT) : kernel_half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_half_reg   <= '0;
            weight_center_reg <= 17'h10000;
            weight_off_reg    <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (ridx == lcer_pkg::REG_KERNEL_HALF)
                kernel_half_reg <= pwdata[2:0];
            else if (ridx == lcer_pkg::REG_WEIGHT_CENTER)
                weight_center_reg <= pwdata[16:0];
            else
                weight_off_reg[(ridx-3'd2)*16 +: 16] <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (ridx == lcer_pkg::REG_KERNEL_HALF)
            prdata = {29'd0, kernel_half_reg};
        else if (ridx == lcer_pkg::REG_WEIGHT_CENTER)
            prdata = {15'd0, weight_center_reg};
        else
            prdata = {16'd0, weight_off_reg[(ridx-3'd2)*16 +: 16]};
    end

    lcer_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .half_eff(half_eff), .sts(sts), .cmd(cmd)
    );

    lcer_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .half_eff(half_eff),
        .weight_center(weight_center_reg), .weight_off(weight_off_reg),
        .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

endmodule

>>> sv/lcer_checker.sv
module lcer_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input lcer_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input lcer_pkg::out_item_t out_data,
    input logic                pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat dropped or changed while waiting");

    a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("results too close together");

endmodule

bind line_convolution_edge_renorm lcer_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .pready(pready)
);
